FILE: rtl/core/hrb_pkg.sv
// hrb_pkg: shared types, codes and constants for the handshake retry/backoff block.
// No dependencies; used by hrb_core and handshake_retry_backoff.
`default_nettype none

package hrb_pkg;

	localparam int AddrW    = 16;
	localparam int VerW     = 16;
	localparam int TpsW     = 13;
	localparam int RetryW   = 4;
	localparam int CountW   = 17;
	localparam int ShiftW   = 3;
	localparam int BackoffCap = 4;
	localparam int PaddrW   = 4;
	localparam int PdataW   = 32;

	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_PARENT    = 2'd1,
		OP_ACK       = 2'd2,
		OP_HANDSHAKE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_NONE     = 3'd0,
		KIND_HS_SENT  = 3'd1,
		KIND_ACK_SENT = 3'd2,
		KIND_ACK_OK   = 3'd3,
		KIND_ACK_BAD  = 3'd4,
		KIND_GAVE_UP  = 3'd5
	} kind_t;

	// register indexes, paddr[3:2]
	typedef enum logic [1:0] {
		REG_NODE_ADDR   = 2'd0,
		REG_TICKS_PER_S = 2'd1,
		REG_RETRY_LIMIT = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	localparam logic [AddrW-1:0]  NodeAddrReset   = 16'd0;
	localparam logic [TpsW-1:0]   TicksReset      = 13'd128;
	localparam logic [RetryW-1:0] RetryLimitReset = 4'd4;
	localparam logic [VerW-1:0]   VersionReset    = 16'd1;

	typedef struct packed {
		op_t              op;
		logic [AddrW-1:0] peer_addr;
		logic [AddrW-1:0] dest_addr;
		logic [VerW-1:0]  version;
	} item_t;

	typedef struct packed {
		kind_t            kind;
		logic [AddrW-1:0] out_addr;
		logic [VerW-1:0]  out_version;
	} result_t;

	typedef struct packed {
		logic [AddrW-1:0]  node_addr;
		logic [TpsW-1:0]   ticks_per_second;
		logic [RetryW-1:0] retry_limit;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/hrb_in_if.sv
// hrb_in_if: valid/ready channel carrying one input word (op, addresses, version).
// Depends on nothing; field widths match hrb_pkg.
`default_nettype none

interface hrb_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] peer_addr;
	logic [15:0] dest_addr;
	logic [15:0] version;

	modport source (output valid, output op, output peer_addr, output dest_addr,
		output version, input ready);
	modport sink (input valid, input op, input peer_addr, input dest_addr,
		input version, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hrb_out_if.sv
// hrb_out_if: valid/ready channel carrying one result word (kind, address, version).
// Depends on nothing; field widths match hrb_pkg.
`default_nettype none

interface hrb_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] out_addr;
	logic [15:0] out_version;

	modport source (output valid, output kind, output out_addr, output out_version,
		input ready);
	modport sink (input valid, input kind, input out_addr, input out_version,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hrb_core.sv
// hrb_core: protocol state (version, parent, retries, timer) and the per-word decision.
// Depends on hrb_pkg.
`default_nettype none

module hrb_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire hrb_pkg::item_t item,
	input  wire hrb_pkg::cfg_t  cfg,
	output hrb_pkg::result_t    res
);

	logic [hrb_pkg::VerW-1:0]   version_q, version_d;
	logic [hrb_pkg::AddrW-1:0]  parent_q, parent_d;
	logic [hrb_pkg::RetryW-1:0] retries_q, retries_d;
	logic [hrb_pkg::CountW-1:0] count_q, count_d;
	logic                       armed_q, armed_d;

	logic [hrb_pkg::RetryW-1:0] next_retry;
	logic [hrb_pkg::ShiftW-1:0] shift;
	logic [hrb_pkg::CountW-1:0] base_count;
	logic [hrb_pkg::VerW-1:0]   version_inc;

	assign next_retry  = retries_q + hrb_pkg::RetryW'(1);
	assign shift       = (next_retry > hrb_pkg::RetryW'(hrb_pkg::BackoffCap))
		? hrb_pkg::ShiftW'(hrb_pkg::BackoffCap) : next_retry[hrb_pkg::ShiftW-1:0];
	assign base_count  = hrb_pkg::CountW'(cfg.ticks_per_second);
	assign version_inc = version_q + hrb_pkg::VerW'(1);

	always_comb begin
		version_d = version_q;
		parent_d  = parent_q;
		retries_d = retries_q;
		count_d   = count_q;
		armed_d   = armed_q;
		res.kind        = hrb_pkg::KIND_NONE;
		res.out_addr    = '0;
		res.out_version = '0;
		case (item.op)
			hrb_pkg::OP_TICK: begin
				if (armed_q) begin
					if (count_q > hrb_pkg::CountW'(1)) begin
						count_d = count_q - hrb_pkg::CountW'(1);
					end else begin
						armed_d = 1'b0;
						count_d = '0;
						if (retries_q < cfg.retry_limit) begin
							retries_d       = next_retry;
							version_d       = version_inc;
							count_d         = base_count << shift;
							armed_d         = 1'b1;
							res.kind        = hrb_pkg::KIND_HS_SENT;
							res.out_addr    = parent_q;
							res.out_version = version_inc;
						end else begin
							retries_d       = '0;
							res.kind        = hrb_pkg::KIND_GAVE_UP;
							res.out_addr    = parent_q;
							res.out_version = version_q;
						end
					end
				end
			end
			hrb_pkg::OP_PARENT: begin
				parent_d = item.peer_addr;
				if (item.peer_addr != '0) begin
					retries_d       = '0;
					version_d       = version_inc;
					count_d         = base_count;
					armed_d         = 1'b1;
					res.kind        = hrb_pkg::KIND_HS_SENT;
					res.out_addr    = item.peer_addr;
					res.out_version = version_inc;
				end
			end
			hrb_pkg::OP_ACK: begin
				if (item.dest_addr == cfg.node_addr) begin
					res.out_addr    = item.peer_addr;
					res.out_version = item.version;
					if (item.version != version_q) begin
						res.kind = hrb_pkg::KIND_ACK_BAD;
					end else begin
						armed_d   = 1'b0;
						count_d   = '0;
						retries_d = '0;
						res.kind  = hrb_pkg::KIND_ACK_OK;
					end
				end
			end
			hrb_pkg::OP_HANDSHAKE: begin
				if (item.dest_addr == cfg.node_addr) begin
					res.kind        = hrb_pkg::KIND_ACK_SENT;
					res.out_addr    = item.peer_addr;
					res.out_version = item.version;
				end
			end
			default: begin
				res.kind = hrb_pkg::KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= hrb_pkg::VersionReset;
			parent_q  <= '0;
			retries_q <= '0;
			count_q   <= '0;
			armed_q   <= 1'b0;
		end else if (fire) begin
			version_q <= version_d;
			parent_q  <= parent_d;
			retries_q <= retries_d;
			count_q   <= count_d;
			armed_q   <= armed_d;
		end
	end

`ifndef SYNTHESIS
	// a disarmed timer always sits at zero
	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> count_q == '0)
		else $error("timer count nonzero while disarmed");

	a_ack_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.kind == hrb_pkg::KIND_ACK_OK |=> !armed_q && retries_q == '0)
		else $error("accepted ack left timer armed");

	a_hs_bumps_version: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.kind == hrb_pkg::KIND_HS_SENT |=>
		armed_q && version_q == hrb_pkg::VerW'($past(version_q) + hrb_pkg::VerW'(1)))
		else $error("handshake did not bump version and arm timer");

	a_give_up_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.kind == hrb_pkg::KIND_GAVE_UP |=> !armed_q && retries_q == '0)
		else $error("give up left retry state behind");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/handshake_retry_backoff.sv
// handshake_retry_backoff: top level with APB register file, input register and result register.
// Depends on hrb_pkg, hrb_in_if, hrb_out_if and hrb_core.
//
// Usage:
//   in_ch carries one word per event: op (tick, parent update, ack received,
//   handshake received) with peer/dest addresses and version. out_ch returns
//   exactly one result word per input word (kind, out_addr, out_version),
//   in order; kind none is delivered like any other result.
//   A word is captured in the input register, decided against the protocol
//   state, and lands in the result register once that register is empty or
//   being drained. Throughput is one word per clock while the receiver does
//   not stall, set by the single decision stage between the two registers.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more word, then in_ch.ready drops until out_ch moves.
//   Reset (arst_n low) empties both registers, sets version to 1, clears
//   parent, retries and timer, and loads node_addr 0, ticks_per_second 128,
//   retry_limit 4. Registers sit at byte offsets 0, 4 and 8 on the APB port;
//   write them only while no word is in flight.
`default_nettype none

module handshake_retry_backoff (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [hrb_pkg::PaddrW-1:0] paddr,
	input  wire logic [hrb_pkg::PdataW-1:0] pwdata,
	output logic      [hrb_pkg::PdataW-1:0] prdata,
	output logic                            pready,
	hrb_in_if.sink                          in_ch,
	hrb_out_if.source                       out_ch
);

	hrb_pkg::cfg_t     cfg_q;
	hrb_pkg::reg_idx_t reg_idx;
	logic              cfg_wr;

	hrb_pkg::item_t    item_s1;
	logic              valid_s1;
	hrb_pkg::result_t  res_comb;
	hrb_pkg::result_t  res_s2;
	logic              valid_s2;
	logic              advance;
	logic              fire;

	// ---- configuration port ----
	assign pready  = 1'b1;
	assign reg_idx = hrb_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_addr        <= hrb_pkg::NodeAddrReset;
			cfg_q.ticks_per_second <= hrb_pkg::TicksReset;
			cfg_q.retry_limit      <= hrb_pkg::RetryLimitReset;
		end else if (cfg_wr) begin
			case (reg_idx)
				hrb_pkg::REG_NODE_ADDR:
					cfg_q.node_addr <= pwdata[hrb_pkg::AddrW-1:0];
				hrb_pkg::REG_TICKS_PER_S:
					cfg_q.ticks_per_second <= pwdata[hrb_pkg::TpsW-1:0];
				hrb_pkg::REG_RETRY_LIMIT:
					cfg_q.retry_limit <= pwdata[hrb_pkg::RetryW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			hrb_pkg::REG_NODE_ADDR:   prdata = hrb_pkg::PdataW'(cfg_q.node_addr);
			hrb_pkg::REG_TICKS_PER_S: prdata = hrb_pkg::PdataW'(cfg_q.ticks_per_second);
			hrb_pkg::REG_RETRY_LIMIT: prdata = hrb_pkg::PdataW'(cfg_q.retry_limit);
			default:                  prdata = '0;
		endcase
	end

	// ---- datapath ----
	// s1 moves on when the result register is empty or being drained
	assign advance     = !valid_s2 || out_ch.ready;
	assign fire        = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.op        <= hrb_pkg::op_t'(in_ch.op);
			item_s1.peer_addr <= in_ch.peer_addr;
			item_s1.dest_addr <= in_ch.dest_addr;
			item_s1.version   <= in_ch.version;
		end
	end

	hrb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	assign out_ch.valid       = valid_s2;
	assign out_ch.kind        = res_s2.kind;
	assign out_ch.out_addr    = res_s2.out_addr;
	assign out_ch.out_version = res_s2.out_version;

`ifndef SYNTHESIS
	// a held result word must not be overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ch.ready |=> valid_s2 && $stable(res_s2))
		else $error("result word lost under stall");

	a_ready_when_s1_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ch.ready)
		else $error("input stalled with empty input register");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("decided word did not reach result register");
`endif

endmodule

`default_nettype wire

FILE: bench/handshake_retry_backoff_tb.sv
// Self-checking bench for handshake_retry_backoff: directed and random event words,
// predicted results compared word by word. Registers set over APB between phases.
// Depends on hrb_pkg, hrb_in_if, hrb_out_if and the handshake_retry_backoff RTL.

module handshake_retry_backoff_tb;
	import hrb_pkg::*;

	typedef struct packed {
		logic [VerW-1:0]   version;
		logic [AddrW-1:0]  parent;
		logic [RetryW-1:0] retries;
		logic [CountW-1:0] count;
		logic              armed;
	} link_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [PaddrW-1:0] paddr = '0;
	logic [PdataW-1:0] pwdata = '0;
	logic [PdataW-1:0] prdata;
	logic              pready;

	logic  in_valid = 1'b0;
	item_t in_word = '0;
	logic  in_fire = 1'b0;
	logic  out_ready = 1'b0;
	logic  calm = 1'b0;
	int    send_gap = 0;
	int    stall_left = 0;

	hrb_in_if  in_ch();
	hrb_out_if out_ch();

	assign in_ch.valid     = in_valid;
	assign in_ch.op        = in_word.op;
	assign in_ch.peer_addr = in_word.peer_addr;
	assign in_ch.dest_addr = in_word.dest_addr;
	assign in_ch.version   = in_word.version;
	assign out_ch.ready    = out_ready;

	handshake_retry_backoff dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	cfg_t        cfg;
	link_state_t planned;   // advanced as words are queued, steers the stimulus
	link_state_t tracked;   // advanced as words are accepted, gives expected results
	item_t       word_feed[$];
	result_t     results_due[$];
	int          errors = 0;
	int          words_in = 0;
	int          results_seen = 0;
	int          busy_items = 0;
	int          setups = 0;

	initial forever #2 clk = ~clk;

	function automatic link_state_t link_reset();
		link_state_t s;
		s.version = VersionReset;
		s.parent  = '0;
		s.retries = '0;
		s.count   = '0;
		s.armed   = 1'b0;
		return s;
	endfunction

	function automatic result_t link_step(inout link_state_t s, input item_t it);
		result_t r;
		logic [ShiftW-1:0] shift;
		r.kind        = KIND_NONE;
		r.out_addr    = '0;
		r.out_version = '0;
		case (it.op)
			OP_TICK: begin
				if (s.armed) begin
					if (s.count > 1) begin
						s.count = s.count - 1'b1;
					end else begin
						s.count = '0;
						s.armed = 1'b0;
						if (s.retries < cfg.retry_limit) begin
							s.retries     = s.retries + 1'b1;
							s.version     = s.version + 1'b1;
							r.kind        = KIND_HS_SENT;
							r.out_addr    = s.parent;
							r.out_version = s.version;
							shift = (s.retries > BackoffCap) ? ShiftW'(BackoffCap)
								: s.retries[ShiftW-1:0];
							s.count = {{(CountW-TpsW){1'b0}}, cfg.ticks_per_second} << shift;
							s.armed = 1'b1;
						end else begin
							s.retries     = '0;
							r.kind        = KIND_GAVE_UP;
							r.out_addr    = s.parent;
							r.out_version = s.version;
						end
					end
				end
			end
			OP_PARENT: begin
				s.parent = it.peer_addr;
				if (s.parent != '0) begin
					s.retries     = '0;
					s.version     = s.version + 1'b1;
					r.kind        = KIND_HS_SENT;
					r.out_addr    = s.parent;
					r.out_version = s.version;
					s.count = {{(CountW-TpsW){1'b0}}, cfg.ticks_per_second};
					s.armed = 1'b1;
				end
			end
			OP_ACK: begin
				if (it.dest_addr == cfg.node_addr) begin
					r.out_addr    = it.peer_addr;
					r.out_version = it.version;
					if (it.version != s.version) begin
						r.kind = KIND_ACK_BAD;
					end else begin
						r.kind    = KIND_ACK_OK;
						s.armed   = 1'b0;
						s.count   = '0;
						s.retries = '0;
					end
				end
			end
			default: begin
				if (it.dest_addr == cfg.node_addr) begin
					r.kind        = KIND_ACK_SENT;
					r.out_addr    = it.peer_addr;
					r.out_version = it.version;
				end
			end
		endcase
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] rnd16();
		return $urandom_range(0, 65535);
	endfunction

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		if (errors < 50)
			$display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic push(input op_t op, input logic [15:0] peer, input logic [15:0] dest,
		input logic [15:0] ver);
		item_t it;
		result_t unused;
		it.op        = op;
		it.peer_addr = peer;
		it.dest_addr = dest;
		it.version   = ver;
		// words that give kind none and leave the state alone don't count toward the traffic goal
		if (!((op == OP_TICK && !planned.armed) ||
			((op == OP_ACK || op == OP_HANDSHAKE) && dest != cfg.node_addr)))
			busy_items++;
		unused = link_step(planned, it);
		word_feed.push_back(it);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [PdataW-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_NODE_ADDR:   cfg.node_addr = value[AddrW-1:0];
			REG_TICKS_PER_S: cfg.ticks_per_second = value[TpsW-1:0];
			REG_RETRY_LIMIT: cfg.retry_limit = value[RetryW-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setup(input logic [AddrW-1:0] node, input logic [TpsW-1:0] tps,
		input logic [RetryW-1:0] retries);
		reg_write(REG_NODE_ADDR, {{(PdataW-AddrW){1'b0}}, node});
		reg_write(REG_TICKS_PER_S, {{(PdataW-TpsW){1'b0}}, tps});
		reg_write(REG_RETRY_LIMIT, {{(PdataW-RetryW){1'b0}}, retries});
		setups++;
	endtask

	// every word gives a result, so once nothing is due the block is idle
	task automatic drain();
		do @(posedge clk);
		while (word_feed.size() != 0 || in_valid || results_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_traffic(input int goal);
		int stop_at;
		int roll;
		int pick;
		stop_at = busy_items + goal;
		while (busy_items < stop_at) begin
			roll = $urandom_range(0, 99);
			pick = $urandom_range(0, 9);
			if (planned.armed && roll < 12) begin
				// run the timer out so resends and give-ups happen often
				repeat (planned.count) push(OP_TICK, rnd16(), rnd16(), rnd16());
			end else if (roll < 45) begin
				push(OP_TICK, rnd16(), rnd16(), rnd16());
			end else if (roll < 57) begin
				if (pick == 0)
					push(OP_PARENT, 16'h0000, rnd16(), rnd16());
				else if (pick == 1)
					push(OP_PARENT, planned.parent, rnd16(), rnd16());
				else
					push(OP_PARENT, $urandom_range(1, 65535), rnd16(), rnd16());
			end else if (roll < 77) begin
				if (pick < 6)
					push(OP_ACK, rnd16(), cfg.node_addr, planned.version);
				else if (pick < 8)
					push(OP_ACK, rnd16(), cfg.node_addr,
						planned.version ^ (16'h0001 << $urandom_range(0, 15)));
				else
					push(OP_ACK, rnd16(), rnd16(), rnd16());
			end else if (roll < 92) begin
				if (pick < 7)
					push(OP_HANDSHAKE, rnd16(), cfg.node_addr, rnd16());
				else
					push(OP_HANDSHAKE, rnd16(), rnd16(), rnd16());
			end else begin
				push(op_t'($urandom_range(0, 3)), rnd16(), rnd16(), rnd16());
			end
		end
	endtask

	// sender
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (word_feed.size() > 0) begin
				in_word  <= word_feed.pop_front();
				in_valid <= 1'b1;
				send_gap <= (calm || $urandom_range(0, 99) < 65) ? 0 : gap_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 15) begin
			stall_left <= gap_len() - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// stretches with no idling on either side
	always @(negedge clk) begin
		if ($urandom_range(0, 299) == 0)
			calm <= ~calm;
	end

	always @(posedge clk) begin
		result_t want;
		in_fire <= arst_n && in_valid && in_ch.ready;
		if (arst_n && in_valid && in_ch.ready) begin
			results_due.push_back(link_step(tracked, in_word));
			words_in++;
		end
		if (arst_n && out_ch.valid && out_ready) begin
			if (results_due.size() == 0) begin
				report("result with nothing due", {13'd0, out_ch.kind}, 16'h0000);
			end else begin
				want = results_due.pop_front();
				results_seen++;
				if (out_ch.kind !== want.kind)
					report("kind", {13'd0, out_ch.kind}, {13'd0, want.kind});
				if (out_ch.out_addr !== want.out_addr)
					report("out_addr", out_ch.out_addr, want.out_addr);
				if (out_ch.out_version !== want.out_version)
					report("out_version", out_ch.out_version, want.out_version);
			end
		end
	end

	initial begin
		#100_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		cfg.node_addr        = NodeAddrReset;
		cfg.ticks_per_second = TicksReset;
		cfg.retry_limit      = RetryLimitReset;
		planned = link_reset();
		tracked = link_reset();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, every op, timer and ack corner cases
		apply_setup(16'hFFFF, 13'd1, 4'd1);
		push(OP_TICK, 16'h0000, 16'h0000, 16'h0000);          // timer idle
		push(OP_ACK, 16'h0000, 16'hFFFF, planned.version);    // ack with no round
		push(OP_ACK, 16'hFFFF, 16'hFFFF, 16'h0000);           // version mismatch
		push(OP_HANDSHAKE, 16'h0000, 16'hFFFF, 16'hFFFF);     // answered
		push(OP_HANDSHAKE, 16'hFFFF, 16'h0000, 16'h0000);     // not ours
		push(OP_ACK, 16'hFFFF, 16'h0000, planned.version);    // not ours
		push(OP_PARENT, 16'h0000, 16'hFFFF, 16'hFFFF);        // no parent, silent
		push(OP_PARENT, 16'hFFFF, 16'h0000, 16'h0000);
		push(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);          // resend, backoff x2
		push(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
		push(OP_TICK, 16'h0000, 16'h0000, 16'h0000);          // gives up
		push(OP_PARENT, 16'h0001, 16'h0000, 16'h0000);
		push(OP_PARENT, 16'h0000, 16'h0000, 16'h0000);        // timer keeps running
		push(OP_TICK, 16'h0000, 16'h0000, 16'h0000);          // resend to address zero
		push(OP_ACK, 16'hFFFF, 16'hFFFF, planned.version);
		push(OP_TICK, 16'h0000, 16'h0000, 16'h0000);          // disarmed by the ack
		push(OP_PARENT, 16'h8000, 16'h0000, 16'h0000);
		push(OP_ACK, 16'h8000, 16'hFFFF, planned.version - 1'b1);
		push(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
		push(OP_ACK, 16'h8000, 16'hFFFF, planned.version);
		drain();

		// long timeout, acked long before it runs out
		apply_setup(16'h0F0F, 13'd4096, 4'd0);
		push(OP_PARENT, 16'h8001, 16'h0F0F, 16'h0000);
		repeat (20) push(OP_TICK, rnd16(), rnd16(), rnd16());
		push(OP_ACK, 16'h8001, 16'h0F0F, planned.version);
		drain();

		// widest register values
		apply_setup(16'hF0F0, 13'h1FFF, 4'hF);
		push(OP_PARENT, 16'h7FFF, 16'h0000, 16'h0000);
		repeat (40) push(OP_TICK, rnd16(), rnd16(), rnd16());
		push(OP_ACK, 16'h7FFF, 16'hF0F0, planned.version);
		drain();

		// zero timeout fires on the next tick
		apply_setup(16'h0001, 13'd0, 4'd3);
		push(OP_PARENT, 16'h00AA, 16'h0000, 16'h0000);
		repeat (6) push(OP_TICK, rnd16(), rnd16(), rnd16());
		drain();

		apply_setup(16'h1234, 13'd1, 4'hF);
		random_traffic(120);
		drain();
		apply_setup(16'hFFFF, 13'd3, 4'd0);
		random_traffic(120);
		drain();
		apply_setup(16'h0000, 13'd2, 4'd7);
		random_traffic(120);
		drain();
		apply_setup(rnd16(), 13'd0, $urandom_range(0, 15));
		random_traffic(120);
		drain();
		apply_setup(16'hA5A5, 13'd5, 4'd4);
		random_traffic(120);
		drain();

		apply_setup(16'h7E57, 13'd2, 4'd3);
		random_traffic(40);
		drain();

		$display("%0d words sent, %0d results checked over %0d register setups",
			words_in, results_seen, setups);
		$display("covered ticks, parent updates, acks, handshakes, backoff and give-up");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/hrb_pkg.sv
rtl/core/hrb_in_if.sv
rtl/core/hrb_out_if.sv
rtl/core/hrb_core.sv
rtl/core/handshake_retry_backoff.sv
bench/handshake_retry_backoff_tb.sv
